>>> rtl/core/csma_pkg.sv
// ----------------------------------------------------------------------------
// csma_pkg
// Shared types, codes and default constants of the CSMA-CA backoff controller.
// ----------------------------------------------------------------------------
package csma_pkg;

	// default parameter values
	localparam int DEF_MAX_EXPONENT = 8;
	localparam int DEF_RANDOM_BITS  = 16;

	// configuration reset values
	localparam logic [7:0] RST_RSSI_THRESHOLD = 8'd50;
	localparam logic [3:0] RST_MIN_BE         = 4'd3;
	localparam logic [3:0] RST_MAX_BE         = 4'd5;
	localparam logic [2:0] RST_MAX_BACKOFFS   = 3'd4;
	localparam logic [2:0] RST_SEND_TRIES     = 3'd2;

	// reported wait saturates just below this
	localparam int WAIT_LIMIT = 'h100;

	// configuration register indexes
	localparam logic [2:0] CFG_RSSI_THRESHOLD = 3'd0;
	localparam logic [2:0] CFG_MIN_BE         = 3'd1;
	localparam logic [2:0] CFG_MAX_BE         = 3'd2;
	localparam logic [2:0] CFG_MAX_BACKOFFS   = 3'd3;
	localparam logic [2:0] CFG_SEND_TRIES     = 3'd4;

	// input action codes
	localparam logic [2:0] ACT_START     = 3'd0;
	localparam logic [2:0] ACT_TICK      = 3'd1;
	localparam logic [2:0] ACT_SAMPLE    = 3'd2;
	localparam logic [2:0] ACT_SEND_DONE = 3'd3;
	localparam logic [2:0] ACT_SEED      = 3'd4;

	// result kinds
	typedef enum logic [1:0] {
		KIND_BACKOFF = 2'd0,
		KIND_SAMPLE  = 2'd1,
		KIND_SEND    = 2'd2,
		KIND_DONE    = 2'd3
	} kind_t;

	// protocol phase of the current request
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_BACKOFF = 2'd1,
		PH_SAMPLE  = 2'd2,
		PH_SEND    = 2'd3
	} phase_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_DIV  = 2'd1,
		ST_EMIT = 2'd2
	} ctrl_state_t;

endpackage

>>> rtl/core/csma_ca_backoff_controller.sv
// ----------------------------------------------------------------------------
// csma_ca_backoff_controller
// Unslotted CSMA-CA transmit controller with an iterative backoff draw.
// ----------------------------------------------------------------------------
// An input word is taken when the sequencer is idle. Words that give no result
// leave the sequencer idle. Words with a result that needs no backoff draw are
// accepted, then loaded into the output register once it is free. Words that
// start a backoff run a restoring remainder unit, one dividend bit per cycle,
// before that load; the input stays stalled until the load. The output register
// holds a finished result while the next input word is already taken.
// Configuration writes are always ready.
module csma_ca_backoff_controller #(
	parameter int MAX_EXPONENT = csma_pkg::DEF_MAX_EXPONENT,
	parameter int RANDOM_BITS  = csma_pkg::DEF_RANDOM_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic        new_seq,
	input  logic [7:0]  frame_seq,
	input  logic [15:0] random_value,
	input  logic [7:0]  rssi,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  wait_ticks,
	output logic [7:0]  seq_out,
	output logic        success
);

	localparam int EW   = MAX_EXPONENT;
	localparam int RW   = RANDOM_BITS;
	localparam int CNTW = $clog2(RW);
	localparam logic [4:0] MAX_EXP5 = 5'(MAX_EXPONENT);

	// configuration registers
	logic [7:0] rssi_threshold_q;
	logic [3:0] min_be_q;
	logic [3:0] max_be_q;
	logic [2:0] max_backoffs_q;
	logic [2:0] send_tries_q;

	// protocol state
	logic [7:0]        seq_counter_q;
	logic [7:0]        frame_seq_held_q;
	logic [3:0]        busy_count_q;
	logic [3:0]        be_q;
	logic [2:0]        tries_done_q;
	logic              any_sent_q;
	csma_pkg::phase_t  phase_q;
	logic [EW-1:0]     ticks_left_q;

	// next values from the accepted word
	logic [7:0]        seq_counter_n;
	logic [7:0]        frame_seq_held_n;
	logic [3:0]        busy_count_n;
	logic [3:0]        be_n;
	logic [2:0]        tries_done_n;
	logic              any_sent_n;
	csma_pkg::phase_t  phase_n;
	logic [EW-1:0]     ticks_left_n;
	logic              has_res;
	logic              need_div;
	csma_pkg::kind_t   res_kind;
	logic              res_ok;

	// sequencer and remainder unit
	csma_pkg::ctrl_state_t state_q, state_n;
	logic [CNTW-1:0]   div_cnt_q;
	logic [RW-1:0]     dvd_q;
	logic [EW-1:0]     rem_q;
	csma_pkg::kind_t   pend_kind_q;
	logic              pend_ok_q;
	logic              in_acc;
	logic              div_step;
	logic              div_last;
	logic              emit_load;
	logic              out_free;

	// output register
	logic              out_valid_q;
	csma_pkg::kind_t   kind_q;
	logic [7:0]        wait_q;
	logic [7:0]        seq_q;
	logic              success_q;

	// helpers
	logic [3:0]        min_be_clamped;
	logic [3:0]        cap_be;
	logic [4:0]        be_inc;
	logic [3:0]        busy_inc;
	logic [2:0]        tries_inc;
	logic              retry;
	logic [EW-1:0]     ticks_dec;
	logic [47:0]       rnd_ext;
	logic [EW-1:0]     divisor;
	logic [EW:0]       trial;
	logic [EW-1:0]     rem_nxt;
	logic [31:0]       rem_ext;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// configuration write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rssi_threshold_q <= csma_pkg::RST_RSSI_THRESHOLD;
			min_be_q         <= csma_pkg::RST_MIN_BE;
			max_be_q         <= csma_pkg::RST_MAX_BE;
			max_backoffs_q   <= csma_pkg::RST_MAX_BACKOFFS;
			send_tries_q     <= csma_pkg::RST_SEND_TRIES;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				csma_pkg::CFG_RSSI_THRESHOLD: rssi_threshold_q <= cfg_data;
				csma_pkg::CFG_MIN_BE:         min_be_q         <= cfg_data[3:0];
				csma_pkg::CFG_MAX_BE:         max_be_q         <= cfg_data[3:0];
				csma_pkg::CFG_MAX_BACKOFFS:   max_backoffs_q   <= cfg_data[2:0];
				csma_pkg::CFG_SEND_TRIES:     send_tries_q     <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// exponent clamps and saturating counters
	always_comb begin
		min_be_clamped = ({1'b0, min_be_q} > MAX_EXP5) ? MAX_EXP5[3:0] : min_be_q;
		cap_be         = ({1'b0, max_be_q} > MAX_EXP5) ? MAX_EXP5[3:0] : max_be_q;
		be_inc         = {1'b0, be_q} + 5'd1;
		busy_inc       = (busy_count_q != 4'hF) ? busy_count_q + 4'd1 : busy_count_q;
		tries_inc      = (tries_done_q != 3'd7) ? tries_done_q + 3'd1 : tries_done_q;
		retry          = tries_inc < send_tries_q;
		ticks_dec      = (ticks_left_q != '0) ? ticks_left_q - EW'(1) : ticks_left_q;
	end

	// protocol step for the accepted word
	always_comb begin
		seq_counter_n    = seq_counter_q;
		frame_seq_held_n = frame_seq_held_q;
		busy_count_n     = busy_count_q;
		be_n             = be_q;
		tries_done_n     = tries_done_q;
		any_sent_n       = any_sent_q;
		phase_n          = phase_q;
		ticks_left_n     = ticks_left_q;
		has_res          = 1'b0;
		need_div         = 1'b0;
		res_kind         = csma_pkg::KIND_BACKOFF;
		res_ok           = 1'b0;
		if (in_acc) begin
			case (action)
				csma_pkg::ACT_START: begin
					if (phase_q == csma_pkg::PH_IDLE) begin
						if (new_seq) begin
							frame_seq_held_n = seq_counter_q;
							seq_counter_n    = seq_counter_q + 8'd1;
						end else begin
							frame_seq_held_n = frame_seq;
						end
						tries_done_n = '0;
						any_sent_n   = 1'b0;
						busy_count_n = '0;
						be_n         = min_be_clamped;
						phase_n      = csma_pkg::PH_BACKOFF;
						has_res      = 1'b1;
						need_div     = 1'b1;
					end
				end
				csma_pkg::ACT_TICK: begin
					if (phase_q == csma_pkg::PH_BACKOFF) begin
						ticks_left_n = ticks_dec;
						if (ticks_dec == '0) begin
							phase_n  = csma_pkg::PH_SAMPLE;
							has_res  = 1'b1;
							res_kind = csma_pkg::KIND_SAMPLE;
						end
					end
				end
				csma_pkg::ACT_SAMPLE: begin
					if (phase_q == csma_pkg::PH_SAMPLE) begin
						if (rssi <= rssi_threshold_q) begin
							phase_n  = csma_pkg::PH_SEND;
							has_res  = 1'b1;
							res_kind = csma_pkg::KIND_SEND;
						end else begin
							busy_count_n = busy_inc;
							be_n = (be_inc < {1'b0, cap_be}) ? be_inc[3:0] : cap_be;
							has_res = 1'b1;
							if (busy_inc > {1'b0, max_backoffs_q}) begin
								// attempt failed
								tries_done_n = tries_inc;
								if (retry) begin
									busy_count_n = '0;
									be_n         = min_be_clamped;
									phase_n      = csma_pkg::PH_BACKOFF;
									need_div     = 1'b1;
								end else begin
									phase_n  = csma_pkg::PH_IDLE;
									res_kind = csma_pkg::KIND_DONE;
									res_ok   = any_sent_q;
								end
							end else begin
								phase_n  = csma_pkg::PH_BACKOFF;
								need_div = 1'b1;
							end
						end
					end
				end
				csma_pkg::ACT_SEND_DONE: begin
					if (phase_q == csma_pkg::PH_SEND) begin
						any_sent_n   = 1'b1;
						tries_done_n = tries_inc;
						has_res      = 1'b1;
						if (retry) begin
							busy_count_n = '0;
							be_n         = min_be_clamped;
							phase_n      = csma_pkg::PH_BACKOFF;
							need_div     = 1'b1;
						end else begin
							phase_n  = csma_pkg::PH_IDLE;
							res_kind = csma_pkg::KIND_DONE;
							res_ok   = 1'b1;
						end
					end
				end
				csma_pkg::ACT_SEED: begin
					seq_counter_n = random_value[7:0];
				end
				default: ;
			endcase
		end
	end

	// remainder unit: divisor 2^be - 1, one dividend bit per cycle
	always_comb begin
		rnd_ext  = {32'b0, random_value};
		divisor  = ~({EW{1'b1}} << be_q);
		trial    = {rem_q, dvd_q[RW-1]};
		rem_nxt  = (trial >= {1'b0, divisor}) ? EW'(trial - {1'b0, divisor}) : trial[EW-1:0];
		div_last = div_step && (div_cnt_q == CNTW'(RW - 1));
		rem_ext  = 32'(rem_q);
	end

	// sequencer next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			csma_pkg::ST_IDLE: begin
				if (in_acc && need_div) begin
					state_n = csma_pkg::ST_DIV;
				end else if (in_acc && has_res) begin
					state_n = csma_pkg::ST_EMIT;
				end
			end
			csma_pkg::ST_DIV: begin
				if (div_cnt_q == CNTW'(RW - 1)) begin
					state_n = csma_pkg::ST_EMIT;
				end
			end
			csma_pkg::ST_EMIT: begin
				if (out_free) begin
					state_n = csma_pkg::ST_IDLE;
				end
			end
			default: state_n = csma_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		div_step  = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			csma_pkg::ST_IDLE: in_stall  = 1'b0;
			csma_pkg::ST_DIV:  div_step  = 1'b1;
			csma_pkg::ST_EMIT: emit_load = out_free;
			default: ;
		endcase
	end

	// control and protocol state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= csma_pkg::ST_IDLE;
			div_cnt_q        <= '0;
			seq_counter_q    <= '0;
			frame_seq_held_q <= '0;
			busy_count_q     <= '0;
			be_q             <= '0;
			tries_done_q     <= '0;
			any_sent_q       <= 1'b0;
			phase_q          <= csma_pkg::PH_IDLE;
			ticks_left_q     <= '0;
		end else begin
			state_q <= state_n;
			if (in_acc) begin
				seq_counter_q    <= seq_counter_n;
				frame_seq_held_q <= frame_seq_held_n;
				busy_count_q     <= busy_count_n;
				be_q             <= be_n;
				tries_done_q     <= tries_done_n;
				any_sent_q       <= any_sent_n;
				phase_q          <= phase_n;
				ticks_left_q     <= ticks_left_n;
				div_cnt_q        <= '0;
			end else if (div_step) begin
				div_cnt_q <= div_cnt_q + CNTW'(1);
				if (div_last) begin
					ticks_left_q <= (be_q == '0) ? '0 : rem_nxt;
				end
			end
		end
	end

	// remainder datapath and pending result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dvd_q       <= rnd_ext[RW-1:0];
			rem_q       <= '0;
			pend_kind_q <= res_kind;
			pend_ok_q   <= res_ok;
		end else if (div_step) begin
			dvd_q <= {dvd_q[RW-2:0], 1'b0};
			rem_q <= (div_last && be_q == '0) ? '0 : rem_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			kind_q    <= pend_kind_q;
			seq_q     <= frame_seq_held_q;
			success_q <= pend_ok_q;
			if (pend_kind_q == csma_pkg::KIND_BACKOFF) begin
				wait_q <= (rem_ext >= 32'(csma_pkg::WAIT_LIMIT)) ? 8'hFF : rem_ext[7:0];
			end else begin
				wait_q <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign wait_ticks = wait_q;
	assign seq_out    = seq_q;
	assign success    = success_q;

	// partial remainder stays below the divisor while the unit runs
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == csma_pkg::ST_DIV && be_q != '0) |-> (rem_q < divisor))
		else $error("remainder not below divisor");

	// a backoff draw only runs in the backoff phase
	a_div_in_backoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == csma_pkg::ST_DIV) |-> (phase_q == csma_pkg::PH_BACKOFF))
		else $error("backoff draw outside backoff phase");

	// a finished request leaves the protocol idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == csma_pkg::ST_EMIT && pend_kind_q == csma_pkg::KIND_DONE)
		|-> (phase_q == csma_pkg::PH_IDLE))
		else $error("request finished while protocol busy");

	// a loaded result shows up on the output next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |=> out_valid_q)
		else $error("loaded result not presented");

	// success only accompanies a finished request
	a_success_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q != csma_pkg::KIND_DONE) |-> !success_q)
		else $error("success flag on wrong kind");

endmodule

>>> dv/csma_ca_backoff_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csma_ca_backoff_controller_tb
// Self-checking bench for the CSMA-CA backoff controller. A scoreboard class
// keeps its own copy of the protocol state and configuration, predicts the
// result of every accepted input word and compares each delivered result
// field by field. Stimulus is a short directed run followed by mostly
// well-formed random transmit requests under several register settings and
// sender and receiver idle profiles.
// ----------------------------------------------------------------------------
module csma_ca_backoff_controller_tb;

	// cycles allowed for a word still in flight after the last result
	localparam int DRAIN_CYCLES = 40;
	// counted random words per register setting
	localparam int SEG_WORDS    = 60;
	localparam int NUM_SEGS     = 12;
	localparam int HOLD_CYCLES  = 300;
	// action code the block never defines
	localparam logic [2:0] ACT_RESERVED = 3'd7;

	typedef struct packed {
		logic [2:0]  action;
		logic        new_seq;
		logic [7:0]  frame_seq;
		logic [15:0] random_value;
		logic [7:0]  rssi;
	} tx_word_t;

	typedef struct packed {
		csma_pkg::kind_t kind;
		logic [7:0]      wait_ticks;
		logic [7:0]      seq_out;
		logic            success;
	} csma_result_t;

	// protocol predictor and store of pending results
	class csma_scoreboard;
		logic [7:0]        thr;
		logic [3:0]        be_min;
		logic [3:0]        be_max;
		logic [2:0]        backoff_limit;
		logic [2:0]        tries_cfg;
		logic [7:0]        seq_ctr;
		logic [7:0]        seq_held;
		logic [3:0]        busy_cnt;
		logic [3:0]        be;
		logic [2:0]        tries_done;
		logic              sent_any;
		csma_pkg::phase_t  ph;
		int unsigned       ticks_left;
		csma_result_t      expected_q[$];
		int                errors;

		function new();
			thr           = csma_pkg::RST_RSSI_THRESHOLD;
			be_min        = csma_pkg::RST_MIN_BE;
			be_max        = csma_pkg::RST_MAX_BE;
			backoff_limit = csma_pkg::RST_MAX_BACKOFFS;
			tries_cfg     = csma_pkg::RST_SEND_TRIES;
			seq_ctr       = '0;
			seq_held      = '0;
			busy_cnt      = '0;
			be            = '0;
			tries_done    = '0;
			sent_any      = 1'b0;
			ph            = csma_pkg::PH_IDLE;
			ticks_left    = 0;
			errors        = 0;
		endfunction

		function int unsigned clamp_exp(int unsigned e);
			return (e > csma_pkg::DEF_MAX_EXPONENT) ? csma_pkg::DEF_MAX_EXPONENT : e;
		endfunction

		function void emit(csma_pkg::kind_t k, int unsigned w, logic ok);
			csma_result_t r;
			r.kind       = k;
			r.wait_ticks = (w > 255) ? 8'hFF : 8'(w);
			r.seq_out    = seq_held;
			r.success    = ok;
			expected_q.push_back(r);
		endfunction

		// random draw is already RANDOM_BITS wide
		function void draw_backoff(logic [15:0] rv);
			int unsigned divisor;
			int unsigned w;
			divisor = (32'd1 << clamp_exp(be)) - 1;
			w = (divisor == 0) ? 0 : (32'(rv) % divisor);
			ticks_left = w;
			ph = csma_pkg::PH_BACKOFF;
			emit(csma_pkg::KIND_BACKOFF, w, 1'b0);
		endfunction

		function void begin_attempt(logic [15:0] rv);
			busy_cnt = '0;
			be = 4'(clamp_exp(be_min));
			draw_backoff(rv);
		endfunction

		function void end_attempt(logic [15:0] rv);
			if (tries_done < 3'd7)
				tries_done++;
			if (tries_done < tries_cfg)
				begin_attempt(rv);
			else begin
				ph = csma_pkg::PH_IDLE;
				emit(csma_pkg::KIND_DONE, 0, sent_any);
			end
		endfunction

		function void write_reg(logic [2:0] idx, logic [7:0] d);
			case (idx)
				csma_pkg::CFG_RSSI_THRESHOLD: thr = d;
				csma_pkg::CFG_MIN_BE:         be_min = d[3:0];
				csma_pkg::CFG_MAX_BE:         be_max = d[3:0];
				csma_pkg::CFG_MAX_BACKOFFS:   backoff_limit = d[2:0];
				csma_pkg::CFG_SEND_TRIES:     tries_cfg = d[2:0];
				default: ;
			endcase
		endfunction

		function void note_word(tx_word_t w);
			int unsigned e;
			int unsigned cap;
			case (w.action)
				csma_pkg::ACT_START: begin
					if (ph == csma_pkg::PH_IDLE) begin
						if (w.new_seq) begin
							seq_held = seq_ctr;
							seq_ctr++;
						end else
							seq_held = w.frame_seq;
						tries_done = '0;
						sent_any = 1'b0;
						begin_attempt(w.random_value);
					end
				end
				csma_pkg::ACT_TICK: begin
					if (ph == csma_pkg::PH_BACKOFF) begin
						if (ticks_left > 0)
							ticks_left--;
						if (ticks_left == 0) begin
							ph = csma_pkg::PH_SAMPLE;
							emit(csma_pkg::KIND_SAMPLE, 0, 1'b0);
						end
					end
				end
				csma_pkg::ACT_SAMPLE: begin
					if (ph == csma_pkg::PH_SAMPLE) begin
						if (w.rssi <= thr) begin
							ph = csma_pkg::PH_SEND;
							emit(csma_pkg::KIND_SEND, 0, 1'b0);
						end else begin
							if (busy_cnt < 4'd15)
								busy_cnt++;
							e = 32'(be) + 1;
							cap = clamp_exp(be_max);
							be = 4'((e < cap) ? e : cap);
							if (busy_cnt > backoff_limit)
								end_attempt(w.random_value);
							else
								draw_backoff(w.random_value);
						end
					end
				end
				csma_pkg::ACT_SEND_DONE: begin
					if (ph == csma_pkg::PH_SEND) begin
						sent_any = 1'b1;
						end_attempt(w.random_value);
					end
				end
				csma_pkg::ACT_SEED: seq_ctr = w.random_value[7:0];
				default: ;
			endcase
		endfunction

		function void cmp_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_word(csma_result_t got);
			csma_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected, actual kind %0d wait %0d seq %0d",
					$time, got.kind, got.wait_ticks, got.seq_out);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			cmp_field("kind", want.kind, got.kind);
			cmp_field("wait_ticks", want.wait_ticks, got.wait_ticks);
			cmp_field("seq_out", want.seq_out, got.seq_out);
			cmp_field("success", want.success, got.success);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  action = '0;
	logic        new_seq = 1'b0;
	logic [7:0]  frame_seq = '0;
	logic [15:0] random_value = '0;
	logic [7:0]  rssi = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  wait_ticks;
	logic [7:0]  seq_out;
	logic        success;

	int sender_idle_pct   = 12;
	int receiver_idle_pct = 61;
	bit hold_req          = 1'b0;
	int hold_left         = 0;

	csma_scoreboard sb = new();

	csma_ca_backoff_controller dut (.*);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random stall, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else
			out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
	end

	// monitor: check delivered results, then note accepted words and writes
	always @(posedge clk) begin
		csma_result_t got;
		tx_word_t     w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{csma_pkg::kind_t'(kind), wait_ticks, seq_out, success};
				sb.check_word(got);
			end
			if (in_valid && !in_stall) begin
				w = '{action, new_seq, frame_seq, random_value, rssi};
				sb.note_word(w);
			end
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// hard limit on run time
	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// offer one word; entered and left at a falling edge
	task automatic send_item(tx_word_t w);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= w.action;
		new_seq      <= w.new_seq;
		frame_seq    <= w.frame_seq;
		random_value <= w.random_value;
		rssi         <= w.rssi;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		@(negedge clk);
	endtask

	task automatic drive(logic [2:0] act, logic ns, logic [7:0] fs, logic [15:0] rv,
			logic [7:0] rs);
		send_item('{act, ns, fs, rv, rs});
	endtask

	// stop offering and wait until every expected result is out
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// one register write, valid stays up for back-to-back writes
	task automatic write_reg(logic [2:0] idx, logic [7:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic program_regs(logic [7:0] thr, logic [3:0] bmin, logic [3:0] bmax,
			logic [2:0] blim, logic [2:0] tries);
		write_reg(csma_pkg::CFG_RSSI_THRESHOLD, thr);
		write_reg(csma_pkg::CFG_MIN_BE, 8'(bmin));
		write_reg(csma_pkg::CFG_MAX_BE, 8'(bmax));
		write_reg(csma_pkg::CFG_MAX_BACKOFFS, 8'(blim));
		write_reg(csma_pkg::CFG_SEND_TRIES, 8'(tries));
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed protocol words with random content, some noise
	function automatic tx_word_t pick_word(output bit shaped);
		tx_word_t w;
		int       roll;
		w.action       = csma_pkg::ACT_TICK;
		w.new_seq      = 1'($urandom);
		w.frame_seq    = 8'($urandom);
		w.random_value = 16'($urandom);
		w.rssi         = 8'($urandom);
		shaped = 1'b1;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			w.action = 3'($urandom_range(0, 7));
			shaped = 1'b0;
		end else if (roll < 13)
			w.action = csma_pkg::ACT_SEED;
		else begin
			case (sb.ph)
				csma_pkg::PH_IDLE:    w.action = csma_pkg::ACT_START;
				csma_pkg::PH_BACKOFF: w.action = csma_pkg::ACT_TICK;
				csma_pkg::PH_SAMPLE: begin
					w.action = csma_pkg::ACT_SAMPLE;
					// busy or free channel about evenly
					if ($urandom_range(0, 1) && sb.thr != 8'hFF)
						w.rssi = 8'($urandom_range(255, 32'(sb.thr) + 1));
					else
						w.rssi = 8'($urandom_range(32'(sb.thr), 0));
				end
				default:    w.action = csma_pkg::ACT_SEND_DONE;
			endcase
		end
		return w;
	endfunction

	// register setting for each stimulus segment
	task automatic configure(int seg);
		logic [3:0] bmin;
		case (seg)
			1: program_regs(8'd255, 4'd8, 4'd8, 3'd7, 3'd1);
			2: program_regs(8'd0, 4'd1, 4'd1, 3'd0, 3'd1);
			3: program_regs(8'd50, 4'd0, 4'd0, 3'd0, 3'd0);
			4: program_regs(8'd128, 4'd6, 4'd2, 3'd3, 3'd7);
			5: program_regs(8'd200, 4'd15, 4'd15, 3'd0, 3'd1);
			default: begin
				bmin = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
					4'($urandom_range(1, 4));
				program_regs(8'($urandom), bmin, 4'($urandom_range(1, 5)),
					3'($urandom), 3'($urandom_range(1, 4)));
			end
		endcase
	endtask

	initial begin : stimulus
		int       seg;
		int       n;
		bit       shaped;
		tx_word_t w;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: out of phase words, seed wrap, start while busy, busy and
		// free channel, threshold edge, two full attempts
		drive(csma_pkg::ACT_TICK, 1'b0, 8'h00, 16'h0000, 8'h00);
		drive(csma_pkg::ACT_SAMPLE, 1'b1, 8'hFF, 16'hFFFF, 8'hFF);
		drive(csma_pkg::ACT_SEND_DONE, 1'b0, 8'h00, 16'h0000, 8'h00);
		drive(ACT_RESERVED, 1'b1, 8'hFF, 16'hFFFF, 8'hFF);
		drive(csma_pkg::ACT_SEED, 1'b0, 8'h00, 16'hFFFF, 8'h00);
		drive(csma_pkg::ACT_START, 1'b1, 8'h00, 16'h0000, 8'h00);
		drive(csma_pkg::ACT_START, 1'b0, 8'hAA, 16'hFFFF, 8'h00);
		drive(csma_pkg::ACT_SEED, 1'b0, 8'h00, 16'h0000, 8'h00);
		drive(csma_pkg::ACT_TICK, 1'b0, 8'h00, 16'hFFFF, 8'h00);
		drive(csma_pkg::ACT_TICK, 1'b0, 8'h00, 16'h0000, 8'h00);
		drive(csma_pkg::ACT_SAMPLE, 1'b0, 8'h00, 16'h0000, 8'd50);
		drive(csma_pkg::ACT_SAMPLE, 1'b0, 8'h00, 16'h0000, 8'd0);
		drive(csma_pkg::ACT_SEND_DONE, 1'b0, 8'h00, 16'h0000, 8'h00);
		drive(csma_pkg::ACT_TICK, 1'b0, 8'h00, 16'h0000, 8'h00);
		drive(csma_pkg::ACT_SAMPLE, 1'b0, 8'h00, 16'h0000, 8'd255);
		drive(csma_pkg::ACT_TICK, 1'b0, 8'h00, 16'h0000, 8'h00);
		drive(csma_pkg::ACT_SAMPLE, 1'b0, 8'h00, 16'hFFFF, 8'd51);
		drive(csma_pkg::ACT_TICK, 1'b0, 8'h00, 16'h0000, 8'h00);
		drive(csma_pkg::ACT_SAMPLE, 1'b0, 8'h00, 16'h0000, 8'd0);
		drive(csma_pkg::ACT_SEND_DONE, 1'b0, 8'h00, 16'h0000, 8'h00);
		drive(csma_pkg::ACT_START, 1'b0, 8'hFF, 16'h0000, 8'h00);
		drive(csma_pkg::ACT_START, 1'b1, 8'h00, 16'h0000, 8'h00);

		// random segments under three idle profiles
		for (seg = 0; seg < NUM_SEGS; seg++) begin
			if (seg == NUM_SEGS / 3) begin
				sender_idle_pct = 61;
				receiver_idle_pct = 12;
			end else if (seg == 2 * NUM_SEGS / 3) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			if (seg != 0) begin
				drain();
				configure(seg);
			end
			if (seg == 2)
				hold_req = 1'b1;
			n = 0;
			while (n < SEG_WORDS) begin
				if (seg == 6 && n == SEG_WORDS / 2)
					drain();
				w = pick_word(shaped);
				send_item(w);
				if (shaped)
					n++;
			end
		end

		drain();
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/csma_pkg.sv
rtl/core/csma_ca_backoff_controller.sv
dv/csma_ca_backoff_controller_tb.sv
